// ===== rtl/polyline_length_xy_top_assert.svh =====
// Assertion macros shared by the checker of the polyline length block.
// Every property is clocked on i_clk and switched off while i_rst_n is low.
`ifndef POLYLINE_LENGTH_XY_TOP_ASSERT_SVH
`define POLYLINE_LENGTH_XY_TOP_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define PLEN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition is followed by a property on the next edge.
`define PLEN_ASSERT_NEXT(label, cond, prop, msg) \
    `PLEN_ASSERT(label, (cond) |=> (prop), msg)

`endif

// ===== rtl/plen_pkg.sv =====
package plen_pkg;

    // Field widths
    localparam int COORD_BITS   = 24;
    localparam int TOTAL_BITS   = 48;

    // Derived datapath widths
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int RAD_BITS     = SQ_BITS + 1;
    localparam int ROOT_BITS    = (RAD_BITS + 1) / 2;
    localparam int RAD_PAD_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS     = ROOT_BITS + 2;
    localparam int CNT_BITS     = $clog2(ROOT_BITS + 1);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MULX,
        S_MULY,
        S_SUM,
        S_ROOT,
        S_EMIT
    } t_state;

    // Absolute difference of two signed coordinates
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS]) begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/plen_if.sv =====
// Vertex channel
interface plen_pt_if;
    import plen_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic                          last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// Result channel
interface plen_res_if;
    import plen_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TOTAL_BITS-1:0]  path_length;
    logic                   length_saturated;

    modport source (output valid, path_length, length_saturated, input ready);
    modport sink   (input valid, path_length, length_saturated, output ready);
endinterface

// Configuration write channel
interface plen_cfg_if;
    logic valid;
    logic ready;
    logic closed_path;

    modport source (output valid, closed_path, input ready);
    modport sink   (input valid, closed_path, output ready);
endinterface

// ===== rtl/polyline_length_xy_top.sv =====
// Polyline XY length. Vertices arrive one beat at a time on i_pt; each vertex
// after the first adds floor(sqrt(dx^2 + dy^2)) to a 48-bit saturating total,
// and the beat flagged last_point closes the polygon, adding the segment back
// to the first vertex when closed_path is set, and yields one result beat on
// o_res. Every vertex after the first goes through operand load, difference,
// two passes through one shared 24x24 multiplier, the sum, then the
// one-bit-per-cycle square root loop and its done pulse. A closing segment
// goes through the same steps, and the result is then handed to the output
// register. i_pt.ready is high only while the sequencer is idle. A result
// waiting on o_res does not stop the next vertex from being taken; it only
// holds the next polygon's end. closed_path may be written at any time via
// i_cfg and is sampled when the last vertex is accepted.
module polyline_length_xy_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    plen_pt_if.sink       i_pt,
    plen_res_if.source    o_res,
    plen_cfg_if.sink      i_cfg
);
    import plen_pkg::*;

    t_state                 r_state;
    t_state                 n_state;

    logic                   r_closed;
    logic                   r_in_poly;
    logic                   r_close_pend;
    logic                   r_last;
    logic [COORD_BITS-1:0]  r_start_x;
    logic [COORD_BITS-1:0]  r_start_y;
    logic [COORD_BITS-1:0]  r_prior_x;
    logic [COORD_BITS-1:0]  r_prior_y;
    logic [COORD_BITS-1:0]  r_ax;
    logic [COORD_BITS-1:0]  r_ay;
    logic [COORD_BITS-1:0]  r_bx;
    logic [COORD_BITS-1:0]  r_by;
    logic [COORD_BITS-1:0]  r_dx;
    logic [COORD_BITS-1:0]  r_dy;
    logic [SQ_BITS-1:0]     r_sqx;
    logic [SQ_BITS-1:0]     r_sqy;
    logic [TOTAL_BITS-1:0]  r_total;
    logic                   r_clamp;
    logic                   r_res_valid;
    logic [TOTAL_BITS-1:0]  r_res_len;
    logic                   r_res_sat;

    logic                   pt_ready;
    logic                   pt_acc;
    logic                   sq_start;
    logic                   sq_done;
    logic [ROOT_BITS-1:0]   sq_root;
    logic [RAD_BITS-1:0]    radicand;
    logic                   emit_go;
    logic [COORD_BITS-1:0]  mul_op;
    logic [SQ_BITS-1:0]     mul_prod;
    logic [TOTAL_BITS:0]    acc_sum;

    // Handshakes
    assign i_pt.ready  = pt_ready;
    assign pt_acc      = i_pt.valid && pt_ready;
    assign i_cfg.ready = 1'b1;

    // Shared squaring multiplier
    assign mul_op   = (r_state == S_MULX) ? r_dx : r_dy;
    assign mul_prod = SQ_BITS'(mul_op) * SQ_BITS'(mul_op);
    assign radicand = RAD_BITS'(r_sqx) + RAD_BITS'(r_sqy);

    // Saturating accumulate of the finished root
    assign acc_sum  = {1'b0, r_total} + (TOTAL_BITS + 1)'(sq_root);

    plen_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (radicand),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state  = r_state;
        pt_ready = 1'b0;
        sq_start = 1'b0;
        emit_go  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                pt_ready = 1'b1;
                if (i_pt.valid) begin
                    if (r_in_poly) begin
                        n_state = S_DIFF;
                    end else if (i_pt.last_point) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIFF: n_state = S_MULX;
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_SUM;
            S_SUM: begin
                sq_start = 1'b1;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                if (sq_done) begin
                    if (r_close_pend) begin
                        n_state = S_DIFF;
                    end else if (r_last) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (!r_res_valid || o_res.ready) begin
                    emit_go = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Polygon control state, total and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed     <= 1'b0;
            r_in_poly    <= 1'b0;
            r_close_pend <= 1'b0;
            r_total      <= '0;
            r_clamp      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_closed <= i_cfg.closed_path;
            end
            if (pt_acc) begin
                if (!r_in_poly) begin
                    r_in_poly    <= 1'b1;
                    r_total      <= '0;
                    r_clamp      <= 1'b0;
                    r_close_pend <= 1'b0;
                end else begin
                    r_close_pend <= i_pt.last_point && r_closed;
                end
            end
            if (r_state == S_ROOT && sq_done) begin
                r_close_pend <= 1'b0;
                if (acc_sum[TOTAL_BITS]) begin
                    r_total <= '1;
                    r_clamp <= 1'b1;
                end else begin
                    r_total <= acc_sum[TOTAL_BITS-1:0];
                end
            end
            if (emit_go) begin
                r_in_poly <= 1'b0;
            end
        end
    end

    // Vertex and segment operands
    always_ff @(posedge i_clk) begin
        if (pt_acc) begin
            r_prior_x <= i_pt.point_x;
            r_prior_y <= i_pt.point_y;
            r_last    <= i_pt.last_point;
            if (!r_in_poly) begin
                r_start_x <= i_pt.point_x;
                r_start_y <= i_pt.point_y;
            end else begin
                r_ax <= r_prior_x;
                r_ay <= r_prior_y;
                r_bx <= i_pt.point_x;
                r_by <= i_pt.point_y;
            end
        end
        // Load the closing segment once the last open segment is in
        if (r_state == S_ROOT && sq_done && r_close_pend) begin
            r_ax <= r_prior_x;
            r_ay <= r_prior_y;
            r_bx <= r_start_x;
            r_by <= r_start_y;
        end
        if (r_state == S_DIFF) begin
            r_dx <= abs_diff(r_ax, r_bx);
            r_dy <= abs_diff(r_ay, r_by);
        end
        if (r_state == S_MULX) begin
            r_sqx <= mul_prod;
        end
        if (r_state == S_MULY) begin
            r_sqy <= mul_prod;
        end
    end

    // Output register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit_go) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_res_len <= r_total;
            r_res_sat <= r_clamp;
        end
    end

    assign o_res.valid            = r_res_valid;
    assign o_res.path_length      = r_res_len;
    assign o_res.length_saturated = r_res_sat;

endmodule

// ===== rtl/plen_sqrt.sv =====
// Bit-serial integer square root: one root bit per cycle, floor result.
module plen_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [plen_pkg::RAD_BITS-1:0]  i_radicand,
    output logic                           o_done,
    output logic [plen_pkg::ROOT_BITS-1:0] o_root
);
    import plen_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_BITS-1:0]     r_cnt;
    logic [RAD_PAD_BITS-1:0] r_rad;
    logic [REM_BITS-1:0]     r_rem;
    logic [ROOT_BITS-1:0]    r_root;

    logic [REM_BITS-1:0]     rem_shift;
    logic [REM_BITS-1:0]     trial;
    logic                    take;

    // Bring down the next pair and try the subtraction
    always_comb begin
        rem_shift = {r_rem[REM_BITS-3:0], r_rad[RAD_PAD_BITS-1 -: 2]};
        trial     = {r_root, 2'b01};
        take      = (rem_shift >= trial);
    end

    // Control: count iterations, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(ROOT_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, advance one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_PAD_BITS'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_PAD_BITS-3:0], 2'b00};
            if (take) begin
                r_rem  <= rem_shift - trial;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem_shift;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/plen_chk.sv =====
`include "polyline_length_xy_top_assert.svh"

// Port-level checks for the polyline length block.
module plen_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_pt_valid,
    input logic                            i_pt_ready,
    input logic                            i_pt_last_point,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic [plen_pkg::TOTAL_BITS-1:0] i_res_path_length,
    input logic                            i_res_length_saturated
);
    import plen_pkg::*;

    logic pt_last_beat;
    logic res_sat_beat;

    assign pt_last_beat = i_pt_valid && i_pt_ready && i_pt_last_point;
    assign res_sat_beat = i_res_valid && i_res_length_saturated;

    // Stalled result beat stays up
    `PLEN_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid, "result dropped")

    // Block goes busy after taking the last vertex of a polygon
    `PLEN_ASSERT_NEXT(a_busy_after_last, pt_last_beat, !i_pt_ready, "ready after last vertex")

    // A new result appears only after a busy cycle
    `PLEN_ASSERT(a_res_from_busy, $rose(i_res_valid) |-> $past(!i_pt_ready), "idle result")

    // Saturated total sits at the ceiling
    `PLEN_ASSERT(a_sat_ceiling, res_sat_beat |-> (&i_res_path_length), "sat below ceiling")

endmodule

bind polyline_length_xy_top plen_chk u_plen_chk (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_pt_valid             (i_pt.valid),
    .i_pt_ready             (i_pt.ready),
    .i_pt_last_point        (i_pt.last_point),
    .i_res_valid            (o_res.valid),
    .i_res_ready            (o_res.ready),
    .i_res_path_length      (o_res.path_length),
    .i_res_length_saturated (o_res.length_saturated)
);
